### rtl/core/velocity_position_pid_assert.svh
// Assertion macros shared by the RTL files of the velocity/position PID.
`ifndef VELOCITY_POSITION_PID_ASSERT_SVH
`define VELOCITY_POSITION_PID_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define VPP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vpp assertion failed");

// Next-cycle implication, disabled while in reset.
`define VPP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vpp assertion failed");

`else

`define VPP_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define VPP_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/vpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vpp_pkg;

	// Serial arithmetic unit geometry
	localparam int OPA_W     = 56;
	localparam int OPB_W     = 24;
	localparam int PROD_W    = OPA_W + OPB_W;
	localparam int DIVR_W    = 7;
	localparam int MUL_STEPS = OPB_W;
	localparam int DIV_STEPS = OPA_W;
	localparam int CNT_W     = 6;

	localparam logic [OPB_W-1:0] CONST_TEN     = 24'd10;
	localparam logic [OPB_W-1:0] CONST_HUNDRED = 24'd100;
	localparam logic [22:0]      VEL_LIMIT     = 23'd6553600;
	localparam logic [13:0]      CAP_MAX       = 14'd10000;
	localparam logic [16:0]      Q_ONE         = 17'd65536;

	localparam logic signed [63:0] SAT_MAX = 64'sh0000_7FFF_FFFF_FFFF;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_GAIN_P    = 3'd0;
	localparam logic [2:0] REG_GAIN_I    = 3'd1;
	localparam logic [2:0] REG_GAIN_D    = 3'd2;
	localparam logic [2:0] REG_INT_LIM   = 3'd3;
	localparam logic [2:0] REG_DEAD_ZONE = 3'd4;
	localparam logic [2:0] REG_MIN_DRIVE = 3'd5;
	localparam logic [2:0] REG_RAMP_SPD  = 3'd6;
	localparam logic [2:0] REG_ALPHA     = 3'd7;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_VEL  = 2'd1,
		KIND_POS  = 2'd2,
		KIND_STOP = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_VEL  = 2'd1,
		MODE_POS  = 2'd2
	} mode_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_VERR,
		ST_VDER,
		ST_RSTEP,
		ST_RAPP,
		ST_RUPD,
		ST_PERR,
		ST_DRAW,
		ST_EMA1,
		ST_EMA2,
		ST_LIM,
		ST_DZ,
		ST_INC,
		ST_MP,
		ST_MI,
		ST_MD,
		ST_OUT,
		ST_CMD
	} state_t;

	// Request to the serial unit
	typedef struct packed {
		logic             start;
		op_t              op;
		logic [OPA_W-1:0] a;
		logic [OPB_W-1:0] b;
	} ser_req_t;

	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = v;
		if (v > SAT_MAX) r = SAT_MAX;
		if (v < -SAT_MAX) r = -SAT_MAX;
		return r[47:0];
	endfunction

	function automatic logic [47:0] mag48(input logic signed [47:0] v);
		logic signed [47:0] r;
		r = (v < 0) ? -v : v;
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/vpp_serial.sv
`timescale 1ns / 1ps
`default_nettype none
`include "velocity_position_pid_assert.svh"

// Bit-serial shift-add multiplier and restoring divider by a small constant.
module vpp_serial import vpp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ser_req_t          req,
	output logic                   done,
	output logic [PROD_W-1:0]      result
);

	logic              busy_q;
	logic              done_q;
	op_t               op_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] p_q;
	logic [OPA_W-1:0]  a_q;
	logic [DIVR_W-1:0] d_q;
	logic [DIVR_W-1:0] rem_q;

	logic [OPA_W:0]    msum;
	logic [DIVR_W:0]   trial;
	logic              ge;

	always_comb begin
		msum  = {1'b0, p_q[PROD_W-1:OPB_W]} + (p_q[0] ? {1'b0, a_q} : '0);
		trial = {rem_q, p_q[OPA_W-1]};
		ge    = (trial >= {1'b0, d_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == OP_MUL) ? CNT_W'(MUL_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			a_q   <= req.a;
			d_q   <= req.b[DIVR_W-1:0];
			rem_q <= '0;
			if (req.op == OP_MUL) p_q <= {{OPA_W{1'b0}}, req.b};
			else p_q <= {{OPB_W{1'b0}}, req.a};
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				// add the multiplicand when the low multiplier bit is set, shift right
				p_q <= {msum, p_q[OPB_W-1:1]};
			end else begin
				// one quotient bit per cycle
				rem_q <= ge ? DIVR_W'(trial - {1'b0, d_q}) : trial[DIVR_W-1:0];
				p_q   <= {p_q[PROD_W-1:OPA_W], p_q[OPA_W-2:0], ge};
			end
		end
	end

	assign done   = done_q;
	assign result = p_q;

	`VPP_ASSERT_NXT(a_start_busy, clk, arst_n, req.start, busy_q)
	`VPP_ASSERT_IMP(a_start_free, clk, arst_n, req.start, !busy_q)
	`VPP_ASSERT_IMP(a_rem_bound, clk, arst_n, busy_q && (op_q == OP_DIV), rem_q < d_q)

endmodule

`default_nettype wire

### rtl/core/velocity_position_pid.sv
`timescale 1ns / 1ps
`default_nettype none
`include "velocity_position_pid_assert.svh"
// A velocity tick runs ST_VERR, ST_VDER, then ST_INC to ST_OUT and ST_CMD. A position tick
// runs ST_RSTEP (no divide at a zero ramp speed; ST_RAPP with approach slowdown and ST_RUPD
// when ramping), then ST_PERR to ST_DZ, and skips ST_INC to ST_OUT inside the deadband. Set
// commands and idle ticks leave the block idle; a stop presents its zero command via ST_CMD.
// One item at a time; a serial multiply or divide holds its state until done, and a stalled
// result holds the block. Reset clears the controller state and restores config defaults.
module velocity_position_pid import vpp_pkg::*; #(
	parameter int APPROACH_FRACTION = 0
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration write port
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_idx,
	input  wire logic [31:0]        cfg_data,
	// input items
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         kind,
	input  wire logic signed [31:0] enc_count,
	input  wire logic signed [31:0] enc_speed,
	input  wire logic signed [31:0] speed_goal,
	input  wire logic signed [31:0] place_goal,
	input  wire logic [15:0]        drive_cap,
	input  wire logic               hold_integral,
	// result items
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [14:0]      drive_command
);

	// Approach slowdown is active only for a fraction within (0, 1].
	localparam bit APP_ON = (APPROACH_FRACTION > 0) && (APPROACH_FRACTION <= 65536);

	// ---------------- configuration registers ----------------
	logic [23:0] gain_p_q, gain_i_q, gain_d_q;
	logic [31:0] ilim_q, dz_q, rspd_q;
	logic [22:0] mindrv_q;
	logic [16:0] alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= 24'd65536;
			gain_i_q <= 24'd32768;
			gain_d_q <= 24'd6554;
			ilim_q   <= '0;
			dz_q     <= '0;
			mindrv_q <= '0;
			rspd_q   <= '0;
			alpha_q  <= Q_ONE;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_GAIN_P:    gain_p_q <= cfg_data[23:0];
				REG_GAIN_I:    gain_i_q <= cfg_data[23:0];
				REG_GAIN_D:    gain_d_q <= cfg_data[23:0];
				REG_INT_LIM:   ilim_q   <= cfg_data;
				REG_DEAD_ZONE: dz_q     <= cfg_data;
				REG_MIN_DRIVE: mindrv_q <= cfg_data[22:0];
				REG_RAMP_SPD:  rspd_q   <= cfg_data;
				REG_ALPHA:     alpha_q  <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// ---------------- controller state ----------------
	state_t             st_q, st_d;
	mode_t              mode_q;
	logic               issued_q;
	logic               out_valid_q;
	logic signed [14:0] cmd_q;

	logic signed [47:0] integ_q, prev_err_q, dfilt_q, ramp_q;
	logic signed [31:0] prev_cnt_q, spd_tgt_q, pos_tgt_q;
	logic [15:0]        cap_q;

	// working registers of one tick
	logic signed [31:0] cnt_q, spd_q;
	logic signed [47:0] err_q, deriv_q, draw_q, inc_q;
	logic [25:0]        step_q;
	logic [22:0]        lim_q;
	logic signed [59:0] acc_q;
	logic signed [23:0] o_q;

	logic in_acc;
	assign in_acc   = in_valid && in_ready;
	assign in_ready = (st_q == ST_IDLE);

	// ---------------- serial unit ----------------
	ser_req_t          req;
	logic              u_done;
	logic [PROD_W-1:0] u_res;
	logic              src_neg;

	vpp_serial u_ser (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.done   (u_done),
		.result (u_res)
	);

	// ---------------- combinational helpers ----------------
	logic signed [32:0] vdiff;
	logic [32:0]        vmag;
	logic signed [48:0] ediff;
	logic [48:0]        emag;
	logic signed [47:0] tgt48, cnt48;
	logic signed [48:0] rdiff;
	logic [48:0]        dmag;
	logic [25:0]        step_eff;
	logic signed [32:0] dc;
	logic [32:0]        dcm;
	logic [16:0]        alpha_eff, alpha_c;
	logic [13:0]        cap_eff;
	logic signed [59:0] term_m, term;
	logic signed [47:0] q_m, qs;
	logic signed [63:0] vd_m, draw_m;
	logic signed [47:0] isum;
	logic signed [59:0] lim60;
	logic signed [23:0] o_pre, o_fin;
	logic               clip;
	logic [23:0]        o_pre_mag;
	logic [22:0]        omag;
	logic [29:0]        p100;
	logic [13:0]        cm, cmc;
	logic               in_dz;

	always_comb begin
		vdiff     = 33'(spd_tgt_q) - 33'(spd_q);
		vmag      = (vdiff < 0) ? 33'(-vdiff) : 33'(vdiff);
		ediff     = 49'(err_q) - 49'(prev_err_q);
		emag      = (ediff < 0) ? 49'(-ediff) : 49'(ediff);
		tgt48     = $signed({pos_tgt_q, 16'h0000});
		cnt48     = $signed({cnt_q, 16'h0000});
		rdiff     = 49'(tgt48) - 49'(ramp_q);
		dmag      = (rdiff < 0) ? 49'(-rdiff) : 49'(rdiff);
		step_eff  = (step_q == '0) ? 26'd1 : step_q;
		dc        = 33'(cnt_q) - 33'(prev_cnt_q);
		dcm       = (dc < 0) ? 33'(-dc) : 33'(dc);
		alpha_eff = ((alpha_q == '0) || (alpha_q > Q_ONE)) ? Q_ONE : alpha_q;
		alpha_c   = Q_ONE - alpha_eff;
		cap_eff   = ((cap_q == '0) || (cap_q > 16'(CAP_MAX))) ? CAP_MAX : cap_q[13:0];

		// signed views of the unit result
		term_m = $signed({1'b0, u_res[74:16]});
		term   = src_neg ? -term_m : term_m;
		q_m    = $signed({1'b0, u_res[46:0]});
		qs     = src_neg ? -q_m : q_m;
		vd_m   = $signed({8'b0, u_res[55:0]});
		draw_m = $signed({8'b0, u_res[39:0], 16'h0000});

		// integral update and clamp
		isum = sat48(64'(integ_q) + 64'(qs));
		if (ilim_q != '0) begin
			if (64'(isum) > $signed({32'b0, ilim_q})) isum = $signed({16'b0, ilim_q});
			if (64'(isum) < -$signed({32'b0, ilim_q})) isum = -$signed({16'b0, ilim_q});
		end

		// output limit, then floor
		lim60 = $signed({37'b0, lim_q});
		clip  = 1'b0;
		if (acc_q > lim60) begin
			o_pre = 24'(lim60);
			clip  = 1'b1;
		end else if (acc_q < -lim60) begin
			o_pre = 24'(-lim60);
			clip  = 1'b1;
		end else begin
			o_pre = 24'(acc_q);
		end
		o_pre_mag = (o_pre < 0) ? 24'(-o_pre) : 24'(o_pre);
		o_fin     = o_pre;
		if ((mode_q == MODE_POS) && (mindrv_q != '0) && (o_pre != '0)
			&& (o_pre_mag < {1'b0, mindrv_q})) begin
			o_fin = (o_pre > 0) ? $signed({1'b0, mindrv_q}) : -$signed({1'b0, mindrv_q});
		end

		// percent x100 command
		omag = (o_q < 0) ? 23'(-o_q) : 23'(o_q);
		p100 = 30'({omag, 6'b0}) + 30'({omag, 5'b0}) + 30'({omag, 2'b0});
		cm   = p100[29:16];
		cmc  = (cm > CAP_MAX) ? CAP_MAX : cm;

		in_dz = (dz_q != '0) && (mag48(err_q) <= {16'b0, dz_q});
	end

	// ---------------- next state ----------------
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (kind == KIND_STOP) st_d = ST_CMD;
					else if (kind == KIND_TICK && mode_q == MODE_VEL) st_d = ST_VERR;
					else if (kind == KIND_TICK && mode_q == MODE_POS) st_d = ST_RSTEP;
				end
			end
			ST_VERR:  if (u_done) st_d = ST_VDER;
			ST_VDER:  if (u_done) st_d = ST_INC;
			ST_RSTEP: begin
				if (rspd_q == '0) st_d = ST_PERR;
				else if (u_done) st_d = APP_ON ? ST_RAPP : ST_RUPD;
			end
			ST_RAPP:  if (u_done) st_d = ST_RUPD;
			ST_RUPD:  st_d = ST_PERR;
			ST_PERR:  st_d = ST_DRAW;
			ST_DRAW:  if (u_done) st_d = ST_EMA1;
			ST_EMA1:  if (u_done) st_d = ST_EMA2;
			ST_EMA2:  if (u_done) st_d = ST_LIM;
			ST_LIM:   if (u_done) st_d = ST_DZ;
			ST_DZ:    st_d = in_dz ? ST_CMD : ST_INC;
			ST_INC:   if (u_done) st_d = ST_MP;
			ST_MP:    if (u_done) st_d = ST_MI;
			ST_MI:    if (u_done) st_d = ST_MD;
			ST_MD:    if (u_done) st_d = ST_OUT;
			ST_OUT:   st_d = ST_CMD;
			ST_CMD:   if (!out_valid_q || out_ready) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	// ---------------- unit requests ----------------
	always_comb begin
		req.op  = OP_MUL;
		req.a   = '0;
		req.b   = '0;
		src_neg = 1'b0;
		unique case (st_q)
			ST_VERR: begin
				req.op  = OP_DIV;
				req.a   = {7'b0, vmag, 16'h0000};
				req.b   = CONST_TEN;
				src_neg = (vdiff < 0);
			end
			ST_VDER: begin
				req.a   = {7'b0, emag};
				req.b   = CONST_HUNDRED;
				src_neg = (ediff < 0);
			end
			ST_RSTEP: begin
				req.op = OP_DIV;
				req.a  = {24'b0, rspd_q};
				req.b  = CONST_HUNDRED;
			end
			ST_RAPP: begin
				req.a = {7'b0, dmag};
				req.b = OPB_W'(APPROACH_FRACTION);
			end
			ST_DRAW: begin
				req.a   = {23'b0, dcm};
				req.b   = CONST_HUNDRED;
				src_neg = (dc < 0);
			end
			ST_EMA1: begin
				req.a   = {8'b0, mag48(draw_q)};
				req.b   = {7'b0, alpha_eff};
				src_neg = (draw_q < 0);
			end
			ST_EMA2: begin
				req.a   = {8'b0, mag48(dfilt_q)};
				req.b   = {7'b0, alpha_c};
				src_neg = (dfilt_q < 0);
			end
			ST_LIM: begin
				req.op = OP_DIV;
				req.a  = OPA_W'({cap_eff, 16'h0000}) + OPA_W'(99);
				req.b  = CONST_HUNDRED;
			end
			ST_INC: begin
				req.op  = OP_DIV;
				req.a   = {8'b0, mag48(err_q)};
				req.b   = CONST_HUNDRED;
				src_neg = (err_q < 0);
			end
			ST_MP: begin
				req.a   = {8'b0, mag48(err_q)};
				req.b   = gain_p_q;
				src_neg = (err_q < 0);
			end
			ST_MI: begin
				req.a   = {8'b0, mag48(integ_q)};
				req.b   = gain_i_q;
				src_neg = (integ_q < 0);
			end
			ST_MD: begin
				req.a   = {8'b0, mag48(deriv_q)};
				req.b   = gain_d_q;
				src_neg = (deriv_q < 0);
			end
			default: ;
		endcase
		// launch once per operation; a zero ramp speed needs no divide
		req.start = !issued_q && (
			st_q == ST_VERR || st_q == ST_VDER || st_q == ST_RAPP || st_q == ST_DRAW ||
			st_q == ST_EMA1 || st_q == ST_EMA2 || st_q == ST_LIM || st_q == ST_INC ||
			st_q == ST_MP || st_q == ST_MI || st_q == ST_MD ||
			(st_q == ST_RSTEP && rspd_q != '0));
	end

	// ---------------- control and controller state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			mode_q      <= MODE_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			integ_q     <= '0;
			prev_err_q  <= '0;
			dfilt_q     <= '0;
			ramp_q      <= '0;
			prev_cnt_q  <= '0;
			spd_tgt_q   <= '0;
			pos_tgt_q   <= '0;
			cap_q       <= '0;
		end else begin
			st_q <= st_d;
			if (req.start) issued_q <= 1'b1;
			else if (u_done) issued_q <= 1'b0;

			// hold a waiting result until taken; load the next one once the slot frees
			if ((st_q == ST_CMD) && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (kind)
							KIND_VEL: begin
								spd_tgt_q  <= speed_goal;
								mode_q     <= MODE_VEL;
								integ_q    <= '0;
								prev_err_q <= '0;
							end
							KIND_POS: begin
								// reseed the ramp only when entering position mode
								if (mode_q != MODE_POS) begin
									ramp_q     <= $signed({enc_count, 16'h0000});
									prev_cnt_q <= enc_count;
									dfilt_q    <= '0;
								end
								pos_tgt_q <= place_goal;
								cap_q     <= drive_cap;
								mode_q    <= MODE_POS;
								if (!hold_integral) integ_q <= '0;
							end
							KIND_STOP: begin
								mode_q  <= MODE_IDLE;
								integ_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_VDER: if (u_done) prev_err_q <= err_q;
				ST_RSTEP: if (rspd_q == '0) ramp_q <= tgt48;
				ST_RUPD: begin
					if (dmag <= {23'b0, step_eff}) ramp_q <= tgt48;
					else if (rdiff > 0) ramp_q <= ramp_q + $signed({22'b0, step_eff});
					else ramp_q <= ramp_q - $signed({22'b0, step_eff});
				end
				ST_EMA2: begin
					if (u_done) begin
						dfilt_q    <= sat48(64'(acc_q) + 64'(term));
						prev_cnt_q <= cnt_q;
					end
				end
				ST_DZ: if (in_dz) dfilt_q <= '0;
				ST_INC: if (u_done) integ_q <= isum;
				ST_OUT: if (clip) integ_q <= sat48(64'(integ_q) - 64'(inc_q));
				default: ;
			endcase
		end
	end

	// ---------------- working registers ----------------
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					cnt_q <= enc_count;
					spd_q <= enc_speed;
					o_q   <= '0;
				end
			end
			ST_VERR: if (u_done) err_q <= qs;
			ST_VDER: begin
				if (u_done) begin
					deriv_q <= sat48(src_neg ? -vd_m : vd_m);
					lim_q   <= VEL_LIMIT;
				end
			end
			ST_RSTEP: if (u_done) step_q <= u_res[25:0];
			ST_RAPP: begin
				// take the approach cap when it is the smaller step
				if (u_done && (u_res[79:16] < {38'b0, step_q})) step_q <= u_res[41:16];
			end
			ST_PERR: err_q <= sat48(64'(ramp_q) - 64'(cnt48));
			ST_DRAW: if (u_done) draw_q <= sat48(src_neg ? draw_m : -draw_m);
			ST_EMA1: if (u_done) acc_q <= term;
			ST_EMA2: if (u_done) deriv_q <= sat48(64'(acc_q) + 64'(term));
			ST_LIM:  if (u_done) lim_q <= u_res[22:0];
			ST_DZ:   if (in_dz) o_q <= '0;
			ST_INC:  if (u_done) inc_q <= qs;
			ST_MP:   if (u_done) acc_q <= term;
			ST_MI:   if (u_done) acc_q <= acc_q + term;
			ST_MD:   if (u_done) acc_q <= acc_q + term;
			ST_OUT:  o_q <= o_fin;
			ST_CMD: begin
				if (!out_valid_q || out_ready)
					cmd_q <= (o_q < 0) ? -$signed({1'b0, cmc}) : $signed({1'b0, cmc});
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign drive_command = cmd_q;

	`VPP_ASSERT_IMP(a_done_issued, clk, arst_n, u_done, issued_q)
	`VPP_ASSERT_IMP(a_idle_integ, clk, arst_n, mode_q == MODE_IDLE, integ_q == '0)
	`VPP_ASSERT_IMP(a_cmd_range, clk, arst_n, out_valid_q, (cmd_q <= 15'sd10000) && (cmd_q >= -15'sd10000))
	`VPP_ASSERT_NXT(a_idle_tick, clk, arst_n, in_acc && (kind == KIND_TICK) && (mode_q == MODE_IDLE), st_q == ST_IDLE)

endmodule

`default_nettype wire
